// ===== hdl/itdt_pkg.sv =====
package itdt_pkg;

  localparam int NUM_DIGITS = 20;
  localparam int BIN_W      = 64;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int STEP_W     = $clog2(BIN_W);
  localparam int DCNT_W     = $clog2(NUM_DIGITS + 1);

  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_A     = 7'h61;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;

  // Conversion modes of the kind field.
  localparam logic [1:0] KIND_UDEC = 2'd0;
  localparam logic [1:0] KIND_SDEC = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;        // take a new item into the datapath
    logic step;        // one shift-and-add-3 step
    logic shift;       // drop the top digit (leading zero)
    logic emit_sign;   // load a minus sign into the output register
    logic emit_digit;  // load the top digit into the output register and drop it
  } cmd_t;

  typedef struct packed {
    logic in_hex;      // mode of the item at the input port
    logic step_last;   // final conversion step
    logic top_zero;    // top digit is zero
    logic dcnt_one;    // one digit left
    logic neg;         // current item is a negative signed value
    logic out_free;    // output register can take a beat this cycle
  } stat_t;

  function automatic logic [6:0] digit_char(input logic [3:0] d);
    logic [6:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {3'd0, d};
    end else begin
      c = CHAR_A + {3'd0, d - 4'd10};
    end
    return c;
  endfunction

endpackage

// ===== hdl/itdt_ctrl.sv =====
module itdt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  itdt_pkg::stat_t stat,
  output itdt_pkg::cmd_t  cmd
);
  import itdt_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = stat.in_hex ? ST_SKIP : ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.step = 1'b1;
        if (stat.step_last) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (stat.top_zero && !stat.dcnt_one) begin
          cmd.shift = 1'b1;
        end else begin
          state_next = stat.neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (stat.out_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_digit = 1'b1;
          if (stat.dcnt_one) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/itdt_dpath.sv =====
module itdt_dpath (
  input  logic           clk,
  input  logic           rst,
  input  logic [1:0]     kind,
  input  logic [63:0]    value,
  input  itdt_pkg::cmd_t  cmd,
  output itdt_pkg::stat_t stat,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [6:0]     char_code,
  output logic           last
);
  import itdt_pkg::*;

  logic [BIN_W-1:0]  bin;
  logic [BCD_W-1:0]  bcd;
  logic [BCD_W-1:0]  bcd_adj;
  logic [STEP_W-1:0] step_cnt;
  logic [DCNT_W-1:0] dcnt;
  logic              neg;
  logic              in_neg;
  logic [BIN_W-1:0]  in_mag;

  assign in_neg = (kind == KIND_SDEC) && value[BIN_W-1];
  assign in_mag = in_neg ? (~value + 64'd1) : value;

  // Add 3 to every BCD digit of 5 or more ahead of the shift.
  always_comb begin
    logic [3:0] d;
    bcd_adj = bcd;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      d = bcd[4*i +: 4];
      bcd_adj[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg      <= in_neg;
      step_cnt <= '0;
      dcnt     <= DCNT_W'(NUM_DIGITS);
      if (kind[1]) begin
        bin <= '0;
        bcd <= {{(BCD_W - BIN_W){1'b0}}, value};
      end else begin
        bin <= in_mag;
        bcd <= '0;
      end
    end else if (cmd.step) begin
      bin      <= {bin[BIN_W-2:0], 1'b0};
      bcd      <= {bcd_adj[BCD_W-2:0], bin[BIN_W-1]};
      step_cnt <= step_cnt + 1'b1;
    end else if (cmd.shift || cmd.emit_digit) begin
      bcd  <= {bcd[BCD_W-5:0], 4'd0};
      dcnt <= dcnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      char_code <= CHAR_MINUS;
      last      <= 1'b0;
    end else if (cmd.emit_digit) begin
      char_code <= digit_char(bcd[BCD_W-1 -: 4]);
      last      <= (dcnt == DCNT_W'(1));
    end
  end

  always_comb begin
    stat.in_hex    = kind[1];
    stat.step_last = (step_cnt == STEP_W'(BIN_W - 1));
    stat.top_zero  = (bcd[BCD_W-1 -: 4] == 4'd0);
    stat.dcnt_one  = (dcnt == DCNT_W'(1));
    stat.neg       = neg;
    stat.out_free  = !out_valid || !out_stall;
  end

endmodule

// ===== hdl/integer_to_digit_text_unit.sv =====
// Sequence: accept the item, run the shift-and-add-3 conversion (decimal only), drop each
// leading zero digit, emit a minus sign if negative, then emit one character per digit.
// Flow: one item at a time, taken only in idle; dropped zeros and digits always total 20,
// and the sign and digit characters wait while the output register is stalled.
// Reset: rst is synchronous and active high; it returns the controller to idle and
// empties the output register.
module integer_to_digit_text_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [63:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  char_code,
  output logic        last
);
  import itdt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  itdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  itdt_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .kind      (kind),
    .value     (value),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_code (char_code),
    .last      (last)
  );

endmodule

// ===== hdl/itdt_checker.sv =====
module itdt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [6:0]  char_code,
  input logic        last
);
  import itdt_pkg::*;

  // A held beat on the output keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(char_code) && $stable(last))
    else $error("output beat changed while stalled");

  // Only digits, a to f, and the minus sign come out.
  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_code >= CHAR_ZERO && char_code <= CHAR_ZERO + 7'd9) ||
                  (char_code >= CHAR_A && char_code <= CHAR_A + 7'd5) ||
                  (char_code == CHAR_MINUS))
    else $error("illegal character code");

  // The minus sign always has digits after it.
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && char_code == CHAR_MINUS |-> !last)
    else $error("minus sign marked last");

  // The block is busy right after taking an item.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

endmodule

bind integer_to_digit_text_unit itdt_checker u_itdt_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import itdt_pkg::*;

  // The package names only the decimal modes; the high bit of kind selects hex.
  localparam logic [1:0] KIND_HEX     = 2'd2;
  localparam logic [1:0] KIND_HEX_ALT = 2'd3;

  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AT_CHAR = 150;
  localparam int DRAIN_CYCLES = 120;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_PRINTS   = 50;

  typedef struct {
    logic [1:0]  kind;
    logic [63:0] value;
    int          gap;
    bit          drain_first;
  } number_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last;
  } text_char_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = KIND_UDEC;
  logic [63:0] value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [6:0]  char_code;
  logic        last;

  number_t    numbers_to_send[$];
  text_char_t chars_due[$];
  number_t    beat;
  text_char_t want;

  logic in_took = 1'b0;
  logic out_took = 1'b0;
  bit   tx_calm = 1'b0;
  bit   rx_calm = 1'b0;
  bit   hold_done = 1'b0;
  int   gap_left = 0;
  int   wait_left = 0;
  int   hold_left = 0;
  int   items_queued = 0;
  int   items_in = 0;
  int   chars_out = 0;
  int   drains = 0;
  int   errors = 0;
  int   cycles = 0;
  int   per_mode[4] = '{0, 0, 0, 0};

  integer_to_digit_text_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_code (char_code),
    .last      (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic note_error(input string msg);
    if (errors < MAX_PRINTS) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    errors++;
  endtask

  // Expected characters of one number, most significant first.
  task automatic predict_text(input logic [1:0] k, input logic [63:0] v);
    logic [63:0] mag;
    logic [63:0] radix;
    logic [63:0] rem;
    logic [3:0]  dig[20];
    logic        neg;
    int          n;
    int          i;
    neg = (k == KIND_SDEC) && v[63];
    mag = neg ? (~v + 64'd1) : v;
    radix = k[1] ? 64'd16 : 64'd10;
    n = 0;
    do begin
      rem = mag % radix;
      dig[n] = rem[3:0];
      mag = mag / radix;
      n++;
    end while (mag != 64'd0);
    if (neg) begin
      chars_due.push_back('{CHAR_MINUS, 1'b0});
    end
    for (i = n - 1; i >= 0; i--) begin
      if (dig[i] < 4'd10) begin
        chars_due.push_back('{CHAR_ZERO + {3'd0, dig[i]}, i == 0});
      end else begin
        chars_due.push_back('{CHAR_A + {3'd0, dig[i] - 4'd10}, i == 0});
      end
    end
  endtask

  task automatic queue_number(input logic [1:0] k, input logic [63:0] v, input bit drain);
    number_t item;
    item.kind = k;
    item.value = v;
    item.gap = tx_calm ? 0 : $urandom_range(0, 3);
    item.drain_first = drain;
    numbers_to_send.push_back(item);
    items_queued++;
  endtask

  // Monitor: predicts on input beats and checks output beats.
  always @(posedge clk) begin
    in_took <= in_valid && !in_stall && !rst;
    out_took <= out_valid && !out_stall && !rst;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_text(kind, value);
        per_mode[kind]++;
        items_in++;
      end
      if (out_valid && !out_stall) begin
        if (chars_due.size() == 0) begin
          note_error($sformatf("unexpected char_code %h last %b", char_code, last));
        end else begin
          want = chars_due.pop_front();
          if (char_code !== want.char_code) begin
            note_error($sformatf("char %0d: char_code %h, expected %h",
                                 chars_out, char_code, want.char_code));
          end
          if (last !== want.last) begin
            note_error($sformatf("char %0d: last %b, expected %b",
                                 chars_out, last, want.last));
          end
        end
        chars_out++;
      end
    end
  end

  // Driver: offers queued numbers, with a per-item gap before the next one.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (numbers_to_send.size() != 0 &&
                   !(numbers_to_send[0].drain_first && chars_due.size() != 0)) begin
        beat = numbers_to_send.pop_front();
        if (beat.drain_first) begin
          drains++;
        end
        kind <= beat.kind;
        value <= beat.value;
        in_valid <= 1'b1;
        gap_left = beat.gap;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall per beat, calm stretches, and one long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && chars_out >= HOLD_AT_CHAR) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (out_took) begin
        if (chars_out % 64 == 0) begin
          rx_calm = ($urandom_range(0, 2) == 0);
        end
        wait_left = rx_calm ? 0 : $urandom_range(0, 3);
      end else if (wait_left > 0) begin
        wait_left--;
      end
      out_stall <= (hold_left > 0) || (wait_left > 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [1:0]  k;
    logic [63:0] w;
    int          n;
    int          len;

    // Directed numbers: zero in every mode, width extremes, sign and digit edges.
    tx_calm = 1'b1;
    queue_number(KIND_UDEC, 64'd0, 1'b0);
    queue_number(KIND_SDEC, 64'd0, 1'b0);
    queue_number(KIND_HEX, 64'd0, 1'b0);
    queue_number(KIND_HEX_ALT, 64'd0, 1'b0);
    queue_number(KIND_UDEC, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    queue_number(KIND_SDEC, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    queue_number(KIND_HEX, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    queue_number(KIND_HEX_ALT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    queue_number(KIND_SDEC, 64'h8000_0000_0000_0000, 1'b0);
    queue_number(KIND_UDEC, 64'h8000_0000_0000_0000, 1'b0);
    queue_number(KIND_SDEC, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    tx_calm = 1'b0;
    queue_number(KIND_UDEC, 64'd10000000000000000000, 1'b0);
    queue_number(KIND_UDEC, 64'd9999999999999999999, 1'b0);
    queue_number(KIND_UDEC, 64'd1, 1'b0);
    queue_number(KIND_UDEC, 64'd9, 1'b1);
    queue_number(KIND_UDEC, 64'd10, 1'b0);
    queue_number(KIND_SDEC, 64'hFFFF_FFFF_FFFF_FFF6, 1'b0);
    queue_number(KIND_SDEC, 64'd10, 1'b0);
    queue_number(KIND_HEX, 64'hF, 1'b0);
    queue_number(KIND_HEX, 64'h10, 1'b0);
    queue_number(KIND_HEX, 64'h0123_4567_89AB_CDEF, 1'b0);
    queue_number(KIND_HEX, 64'hFEDC_BA98_7654_3210, 1'b0);
    queue_number(KIND_HEX_ALT, 64'hDEAD_BEEF, 1'b0);

    // Random numbers with a random bit length, so short and long texts both occur.
    for (n = 0; n < 210; n++) begin
      tx_calm = (n >= 60 && n < 100);
      k = 2'($urandom_range(0, 3));
      w = {$urandom, $urandom};
      len = $urandom_range(1, 64);
      if (len < 64) begin
        w &= (64'd1 << len) - 64'd1;
      end
      if (k == KIND_SDEC && $urandom_range(0, 1) == 1) begin
        w = ~w + 64'd1;
      end
      queue_number(k, w, n == 140);
    end

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    while (items_in < items_queued || chars_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Converted %0d numbers (unsigned %0d, signed %0d, hex %0d, mode 3 %0d)",
             items_in, per_mode[0], per_mode[1], per_mode[2], per_mode[3]);
    $display("Checked %0d characters; %0d drain pauses, %0d-cycle output hold-off",
             chars_out, drains, HOLD_CYCLES);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/itdt_pkg.sv
hdl/itdt_ctrl.sv
hdl/itdt_dpath.sv
hdl/integer_to_digit_text_unit.sv
hdl/itdt_checker.sv
tb/testbench.sv
